// ----- rtl/rrts_pkg.sv -----
// ----------------------------------------------------------------------------
// rrts_pkg: shared types for the round-robin task scheduler
// operation and status codes, sequencer states, result beat layout
// ----------------------------------------------------------------------------
package rrts_pkg;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_CREATE = 3'd1,
        OP_FORK   = 3'd2,
        OP_EXIT   = 3'd3,
        OP_SLEEP  = 3'd4,
        OP_WAIT   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_TASK  = 3'd1,
        ST_NO_STACK = 3'd2,
        ST_NO_TIMER = 3'd3,
        ST_EMPTY    = 3'd4,
        ST_NOT_LIVE = 3'd5
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_T_SCAN,
        S_T_RD,
        S_T_ADV,
        S_WAKE,
        S_INS,
        S_INS_RD,
        S_INS_WB,
        S_REM,
        S_REM_RD,
        S_BLOCK,
        S_F_TSCAN,
        S_F_SSCAN,
        S_X_RD,
        S_X_DO,
        S_S_SCAN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic dec;
        logic load;
    } timer_ctl_t;

    typedef struct packed {
        status_t     status;
        logic [3:0]  current_task;
        logic        current_valid;
        logic [7:0]  new_task_id;
        logic [3:0]  stack_slot;
        logic [31:0] tick_count;
    } result_t;

endpackage

// ----- rtl/rrts_in_if.sv -----
// ----------------------------------------------------------------------------
// rrts_in_if: operation request channel
// valid/ready with one operation per beat
// ----------------------------------------------------------------------------
interface rrts_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic [15:0] sleep_ticks;
    logic [7:0]  task_id;

    modport source (output valid, operation, sleep_ticks, task_id, input ready);
    modport sink   (input valid, operation, sleep_ticks, task_id, output ready);
endinterface

// ----- rtl/rrts_out_if.sv -----
// ----------------------------------------------------------------------------
// rrts_out_if: result channel
// valid/ready with one result per beat
// ----------------------------------------------------------------------------
interface rrts_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  current_task;
    logic        current_valid;
    logic [7:0]  new_task_id;
    logic [3:0]  stack_slot;
    logic [31:0] tick_count;

    modport source (output valid, status, current_task, current_valid, new_task_id,
                    stack_slot, tick_count, input ready);
    modport sink   (input valid, status, current_task, current_valid, new_task_id,
                    stack_slot, tick_count, output ready);
endinterface

// ----- rtl/rrts_cfg_if.sv -----
// ----------------------------------------------------------------------------
// rrts_cfg_if: configuration write channel
// valid/ready, one register write per beat
// ----------------------------------------------------------------------------
interface rrts_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/round_robin_task_scheduler_unit.sv -----
// ----------------------------------------------------------------------------
// round_robin_task_scheduler_unit: round-robin scheduler over a task table
// ready ring in link rams, sleep timers, stack slot and task allocation
// ----------------------------------------------------------------------------
// usage
//   req  : one operation per beat (tick, create, fork, exit, sleep, wait)
//   rsp  : exactly one result beat per request beat, in order
//   cfg  : id_offset write, always ready; write only while the block is idle
// timing
//   a request is taken only when the sequencer is idle, then walked step by
//   step through one scan counter and the link rams (registered reads):
//     tick        up to TIMERS + 4 cycles, plus up to 4 per expiring timer
//     create/fork up to TASKS + STACKS + 4 cycles (two scans, ring insert)
//     exit        5 to 9 cycles, sleep up to TIMERS + 4, wait 4
//   the result goes into an output register, so the next request can be
//   taken while a result waits; a stalled rsp holds the sequencer in its
//   last step until the output register frees up
// reset
//   rst_n clears task table, timers, stack map, tick counter and id_offset;
//   link rams need no clearing pass, so the block is ready right after reset
// ----------------------------------------------------------------------------
module round_robin_task_scheduler_unit #(
    parameter int TASKS  = 16,
    parameter int TIMERS = 8,
    parameter int STACKS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    rrts_in_if.sink    req,
    rrts_out_if.source rsp,
    rrts_cfg_if.sink   cfg
);
    import rrts_pkg::*;

    logic       cfg_write;
    logic [7:0] id_offset_reg;
    logic       core_idle;
    logic       core_done;
    logic       take;
    logic       out_valid_reg, out_valid_next;
    result_t    core_result;
    result_t    result_reg;

    // the config port never stalls
    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_offset_reg <= 8'd0;
        end
        else if (cfg_write)
        begin
            id_offset_reg <= cfg.data;
        end
    end

    // requests only while the sequencer is idle
    assign req.ready = core_idle;

    rrts_core #(.TASKS(TASKS), .TIMERS(TIMERS), .STACKS(STACKS)) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (req.valid && req.ready),
        .operation   (req.operation),
        .sleep_ticks (req.sleep_ticks),
        .task_id     (req.task_id),
        .id_offset   (id_offset_reg),
        .take        (take),
        .idle        (core_idle),
        .done        (core_done),
        .result      (core_result)
    );

    // output register, loaded when empty or being drained this cycle
    assign take = core_done && (!out_valid_reg || rsp.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= core_result;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = result_reg.status;
    assign rsp.current_task  = result_reg.current_task;
    assign rsp.current_valid = result_reg.current_valid;
    assign rsp.new_task_id   = result_reg.new_task_id;
    assign rsp.stack_slot    = result_reg.stack_slot;
    assign rsp.tick_count    = result_reg.tick_count;
endmodule

// ----- rtl/rrts_ram.sv -----
// ----------------------------------------------------------------------------
// rrts_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rrts_timer_bank.sv -----
// ----------------------------------------------------------------------------
// rrts_timer_bank: sleep timer slots
// one shared decrement and zero/one compare, addressed by the scan index
// ----------------------------------------------------------------------------
module rrts_timer_bank #(
    parameter int TIMERS  = 8,
    parameter int OWNER_W = 4,
    parameter int TMW     = (TIMERS > 1) ? $clog2(TIMERS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [TMW-1:0]      idx,
    input  rrts_pkg::timer_ctl_t ctl,
    input  logic [15:0]         load_ticks,
    input  logic [OWNER_W-1:0]  load_owner,
    output logic                is_zero,
    output logic                is_one,
    output logic [OWNER_W-1:0]  owner
);
    import rrts_pkg::*;

    logic [15:0]        remaining_reg [TIMERS];
    logic [OWNER_W-1:0] owner_reg     [TIMERS];
    logic [15:0]        cur;

    assign cur     = remaining_reg[idx];
    assign is_zero = (cur == 16'd0);
    assign is_one  = (cur == 16'd1);
    assign owner   = owner_reg[idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TIMERS; i++)
            begin
                remaining_reg[i] <= 16'd0;
            end
        end
        else if (ctl.load)
        begin
            remaining_reg[idx] <= load_ticks;
        end
        else if (ctl.dec)
        begin
            remaining_reg[idx] <= cur - 16'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            owner_reg[idx] <= load_owner;
        end
    end
endmodule

// ----- rtl/rrts_core.sv -----
// ----------------------------------------------------------------------------
// rrts_core: scheduler sequencer
// walks one operation through scan, link ram and ring update steps
// ----------------------------------------------------------------------------
module rrts_core #(
    parameter int TASKS  = 16,
    parameter int TIMERS = 8,
    parameter int STACKS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [2:0]        operation,
    input  logic [15:0]       sleep_ticks,
    input  logic [7:0]        task_id,
    input  logic [7:0]        id_offset,
    input  logic              take,
    output logic              idle,
    output logic              done,
    output rrts_pkg::result_t result
);
    import rrts_pkg::*;

    localparam int TW   = $clog2(TASKS);
    localparam int PW   = $clog2(TASKS + 1);
    localparam int SW   = (STACKS > 1) ? $clog2(STACKS) : 1;
    localparam int TMW  = (TIMERS > 1) ? $clog2(TIMERS) : 1;
    localparam int MX1  = (TASKS > STACKS) ? TASKS : STACKS;
    localparam int MAXN = (MX1 > TIMERS) ? MX1 : TIMERS;
    localparam int IW   = $clog2(MAXN + 1);

    state_t            state_reg, state_next;
    state_t            ret_reg, ret_next;
    logic [TW-1:0]     run_reg, run_next;
    logic              rv_reg, rv_next;
    logic [TASKS-1:0]  used_reg, used_next;
    logic [TASKS-1:0]  blocked_reg, blocked_next;
    logic [STACKS-1:0] stk_reg, stk_next;
    logic [31:0]       clock_reg, clock_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [TW-1:0]     wake_reg, wake_next;
    logic [TW-1:0]     nsave_reg, nsave_next;
    logic [PW-1:0]     parent_reg, parent_next;
    logic [15:0]       ticks_reg, ticks_next;
    status_t           status_reg, status_next;
    logic [7:0]        new_id_reg, new_id_next;
    logic [3:0]        slot_reg, slot_next;

    // link and per-task rams, all read at the running task
    logic          nx_we, pv_we, tk_we;
    logic [TW-1:0] nx_waddr, nx_wdata, pv_waddr, pv_wdata, nx_rdata, pv_rdata;
    logic [SW-1:0] st_wdata, st_rdata;
    logic [PW-1:0] pa_rdata;

    timer_ctl_t    tctl;
    logic          tm_zero, tm_one;
    logic [TW-1:0] tm_owner;

    logic [7:0]    wait_t;

    rrts_ram #(.WIDTH(TW), .DEPTH(TASKS)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
        .raddr(run_reg), .rdata(nx_rdata)
    );
    rrts_ram #(.WIDTH(TW), .DEPTH(TASKS)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
        .raddr(run_reg), .rdata(pv_rdata)
    );
    rrts_ram #(.WIDTH(SW), .DEPTH(TASKS)) u_stack_ram (
        .clk(clk), .we(tk_we), .waddr(wake_reg), .wdata(st_wdata),
        .raddr(run_reg), .rdata(st_rdata)
    );
    rrts_ram #(.WIDTH(PW), .DEPTH(TASKS)) u_parent_ram (
        .clk(clk), .we(tk_we), .waddr(wake_reg), .wdata(parent_reg),
        .raddr(run_reg), .rdata(pa_rdata)
    );

    rrts_timer_bank #(.TIMERS(TIMERS), .OWNER_W(TW)) u_timers (
        .clk(clk), .rst_n(rst_n), .idx(idx_reg[TMW-1:0]), .ctl(tctl),
        .load_ticks(ticks_reg), .load_owner(run_reg),
        .is_zero(tm_zero), .is_one(tm_one), .owner(tm_owner)
    );

    assign wait_t = task_id ^ id_offset;
    assign idle   = (state_reg == S_IDLE);
    assign done   = (state_reg == S_DONE);

    assign result.status        = status_reg;
    assign result.current_task  = rv_reg ? 4'(run_reg) : 4'd0;
    assign result.current_valid = rv_reg;
    assign result.new_task_id   = new_id_reg;
    assign result.stack_slot    = slot_reg;
    assign result.tick_count    = clock_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            run_reg     <= '0;
            rv_reg      <= 1'b0;
            used_reg    <= '0;
            blocked_reg <= '0;
            stk_reg     <= '0;
            clock_reg   <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            run_reg     <= run_next;
            rv_reg      <= rv_next;
            used_reg    <= used_next;
            blocked_reg <= blocked_next;
            stk_reg     <= stk_next;
            clock_reg   <= clock_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wake_reg   <= wake_next;
        nsave_reg  <= nsave_next;
        parent_reg <= parent_next;
        ticks_reg  <= ticks_next;
        status_reg <= status_next;
        new_id_reg <= new_id_next;
        slot_reg   <= slot_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        run_next     = run_reg;
        rv_next      = rv_reg;
        used_next    = used_reg;
        blocked_next = blocked_reg;
        stk_next     = stk_reg;
        clock_next   = clock_reg;
        idx_next     = idx_reg;
        wake_next    = wake_reg;
        nsave_next   = nsave_reg;
        parent_next  = parent_reg;
        ticks_next   = ticks_reg;
        status_next  = status_reg;
        new_id_next  = new_id_reg;
        slot_next    = slot_reg;
        nx_we        = 1'b0;
        nx_waddr     = wake_reg;
        nx_wdata     = wake_reg;
        pv_we        = 1'b0;
        pv_waddr     = wake_reg;
        pv_wdata     = wake_reg;
        tk_we        = 1'b0;
        st_wdata     = idx_reg[SW-1:0];
        tctl         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = ST_OK;
                    new_id_next = '0;
                    slot_next   = '0;
                    idx_next    = '0;
                    ticks_next  = sleep_ticks;
                    priority if (operation == OP_TICK)
                    begin
                        clock_next = clock_reg + 32'd1;
                        state_next = S_T_SCAN;
                    end
                    else if (operation == OP_CREATE)
                    begin
                        parent_next = PW'(TASKS);
                        state_next  = S_F_TSCAN;
                    end
                    else if ((operation == OP_FORK || operation == OP_EXIT ||
                              operation == OP_SLEEP || operation == OP_WAIT) && !rv_reg)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else if (operation == OP_FORK)
                    begin
                        parent_next = PW'(run_reg);
                        state_next  = S_F_TSCAN;
                    end
                    else if (operation == OP_EXIT)
                    begin
                        state_next = S_X_RD;
                    end
                    else if (operation == OP_SLEEP)
                    begin
                        state_next = (sleep_ticks == 16'd0) ? S_DONE : S_S_SCAN;
                    end
                    else if (operation == OP_WAIT)
                    begin
                        if (wait_t >= 8'(TASKS) || !used_reg[wait_t[TW-1:0]])
                        begin
                            status_next = ST_NOT_LIVE;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_BLOCK;
                        end
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            // count down each slot, wake its owner on expiry
            S_T_SCAN:
            begin
                if (idx_reg == IW'(TIMERS))
                begin
                    state_next = rv_reg ? S_T_RD : S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (!tm_zero)
                    begin
                        tctl.dec = 1'b1;
                        if (tm_one)
                        begin
                            wake_next  = tm_owner;
                            ret_next   = S_T_SCAN;
                            state_next = S_WAKE;
                        end
                    end
                end
            end
            S_T_RD:  state_next = S_T_ADV;
            S_T_ADV:
            begin
                run_next   = nx_rdata;
                state_next = S_DONE;
            end

            S_WAKE:
            begin
                if (used_reg[wake_reg] && blocked_reg[wake_reg])
                begin
                    blocked_next[wake_reg] = 1'b0;
                    state_next             = S_INS;
                end
                else
                begin
                    state_next = ret_reg;
                end
            end

            // link wake_reg in right after the running task, or make it the only one if none runs
            S_INS:
            begin
                if (!rv_reg)
                begin
                    nx_we      = 1'b1;
                    pv_we      = 1'b1;
                    run_next   = wake_reg;
                    rv_next    = 1'b1;
                    state_next = ret_reg;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD:
            begin
                nsave_next = nx_rdata;
                nx_we      = 1'b1;
                nx_wdata   = nx_rdata;
                pv_we      = 1'b1;
                pv_wdata   = run_reg;
                state_next = S_INS_WB;
            end
            S_INS_WB:
            begin
                nx_we      = 1'b1;
                nx_waddr   = run_reg;
                pv_we      = 1'b1;
                pv_waddr   = nsave_reg;
                state_next = ret_reg;
            end

            S_BLOCK:
            begin
                blocked_next[run_reg] = 1'b1;
                state_next            = S_REM;
            end
            S_REM:   state_next = S_REM_RD;
            S_REM_RD:
            begin
                if (nx_rdata == run_reg)
                begin
                    rv_next     = 1'b0;
                    status_next = ST_EMPTY;
                end
                else
                begin
                    nx_we    = 1'b1;
                    nx_waddr = pv_rdata;
                    nx_wdata = nx_rdata;
                    pv_we    = 1'b1;
                    pv_waddr = nx_rdata;
                    pv_wdata = pv_rdata;
                    run_next = nx_rdata;
                end
                state_next = S_DONE;
            end

            // lowest free task entry, then lowest free stack slot
            S_F_TSCAN:
            begin
                if (idx_reg == IW'(TASKS))
                begin
                    status_next = ST_NO_TASK;
                    state_next  = S_DONE;
                end
                else if (!used_reg[idx_reg[TW-1:0]])
                begin
                    wake_next  = idx_reg[TW-1:0];
                    idx_next   = '0;
                    state_next = S_F_SSCAN;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_F_SSCAN:
            begin
                if (idx_reg == IW'(STACKS))
                begin
                    status_next = ST_NO_STACK;
                    state_next  = S_DONE;
                end
                else if (!stk_reg[idx_reg[SW-1:0]])
                begin
                    stk_next[idx_reg[SW-1:0]] = 1'b1;
                    used_next[wake_reg]       = 1'b1;
                    blocked_next[wake_reg]    = 1'b0;
                    tk_we                     = 1'b1;
                    new_id_next               = 8'(wake_reg) ^ id_offset;
                    slot_next                 = 4'(idx_reg[SW-1:0]);
                    ret_next                  = S_DONE;
                    state_next                = S_INS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_X_RD:  state_next = S_X_DO;
            S_X_DO:
            begin
                stk_next[st_rdata]    = 1'b0;
                used_next[run_reg]    = 1'b0;
                blocked_next[run_reg] = 1'b0;
                if (pa_rdata < PW'(TASKS))
                begin
                    wake_next  = pa_rdata[TW-1:0];
                    ret_next   = S_REM;
                    state_next = S_WAKE;
                end
                else
                begin
                    state_next = S_REM;
                end
            end

            S_S_SCAN:
            begin
                if (idx_reg == IW'(TIMERS))
                begin
                    status_next = ST_NO_TIMER;
                    state_next  = S_DONE;
                end
                else if (tm_zero)
                begin
                    tctl.load  = 1'b1;
                    state_next = S_BLOCK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (take)
                begin
                    state_next = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // every live task owns exactly one stack slot between operations
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ($countones(stk_reg) == $countones(used_reg)))
        else $error("stack map and task table disagree");

    // the running task is live and not blocked between operations
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && rv_reg) |-> (used_reg[run_reg] && !blocked_reg[run_reg]))
        else $error("running task is free or blocked");

    // the tick counter moves only when a tick is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |=> $stable(clock_reg))
        else $error("tick counter moved outside a tick");
endmodule
